// ===== src/multi_waveform_generator_macros.svh =====
// assertion helpers shared by the block
`ifndef MULTI_WAVEFORM_GENERATOR_MACROS_SVH
`define MULTI_WAVEFORM_GENERATOR_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define MWG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("multi waveform generator check failed");

// next-cycle implication, ignored while reset is held
`define MWG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("multi waveform generator check failed");

`endif

// ===== src/mwg_pkg.sv =====
`default_nettype none
package mwg_pkg;

    // field and datapath widths
    localparam int WAVE_W  = 3;
    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 16;
    localparam int CNT_W   = 23;
    localparam int WORD_W  = 16;
    localparam int FT_W    = FREQ_W + CNT_W;
    localparam int DENW    = 19;
    localparam int QUOW    = 16;
    localparam int PER_W   = 10;
    localparam int MAG_W   = 15;
    localparam int STAIR_W = 15;

    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int MIN_PERIOD           = 2;
    localparam int PERIOD_NUM           = 1000;
    localparam int FRAC_SHIFT           = 14;
    localparam int STAIR_STEPS          = 20;
    localparam int STAIR_HALF           = 10;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_ABS    = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_STAIR  = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd5;

    // register indexes
    localparam logic [1:0] REG_WAVEFORM  = 2'd0;
    localparam logic [1:0] REG_FREQUENCY = 2'd1;
    localparam logic [1:0] REG_DURATION  = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PDIV,
        ST_CDIV,
        ST_SEL,
        ST_MUL,
        ST_PHDIV,
        ST_ROM,
        ST_SCALE,
        ST_FIN,
        ST_RDIV,
        ST_STAIR,
        ST_WRITE
    } t_state;

    // phase divisor per sine-based mode
    function automatic logic [DENW-1:0] phase_den(input logic [WAVE_W-1:0] mode);
        logic [DENW-1:0] d;
        unique case (mode)
            WAVE_SINE:   d = 19'd360000;
            WAVE_SQUARE: d = 19'd1000;
            default:     d = 19'd36000;
        endcase
        return d;
    endfunction

    // staircase level n*32768/20
    function automatic logic [WORD_W-1:0] stair_level(input logic [3:0] n);
        logic [WORD_W-1:0] v;
        unique case (n)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd1638;
            4'd2:    v = 16'd3276;
            4'd3:    v = 16'd4915;
            4'd4:    v = 16'd6553;
            4'd5:    v = 16'd8192;
            4'd6:    v = 16'd9830;
            4'd7:    v = 16'd11468;
            4'd8:    v = 16'd13107;
            4'd9:    v = 16'd14745;
            4'd10:   v = 16'd16384;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // restoring long division, used only while building the sine table
    function automatic longint unsigned long_div(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave magnitude 16384*sin(p*pi/(2N)), N = 2**logn, taylor series in Q30
    function automatic logic [MAG_W-1:0] quarter_sine(input longint unsigned p,
                                                     input int unsigned logn);
        longint unsigned n;
        longint unsigned x;
        longint unsigned t;
        longint unsigned s;
        longint unsigned k;
        bit sub;
        n = 64'd1 << logn;
        if (p == 0) return '0;
        if (p == n) return 15'd16384;
        if (3 * p == n) return 15'd8192;
        x = (p * PI_Q30) >> (logn + 1);
        s = x;
        t = x;
        k = 1;
        sub = 1'b1;
        for (int i = 0; i < 64; i++) begin
            if (t != 0) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = long_div(t, (k + 1) * (k + 2));
                k = k + 2;
                if (sub) s = s - t;
                else s = s + t;
                sub = !sub;
            end
        end
        s = s >> 16;
        if (s > 64'd16384) s = 64'd16384;
        return s[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/multi_waveform_generator.sv =====
`default_nettype none
`include "multi_waveform_generator_macros.svh"
// Multi-waveform generator: each request on the input stream is one tick and gives exactly
// one result word (sine, square, triangle, abs sine, staircase or sawtooth), with tlast and
// a zero word once the run set by the duration register has ended; restart puts the tick
// count back to 1. One request is worked on at a time, through a single bit-serial divider
// of W = 39 + log2(SINE_TABLE_DEPTH) steps (49 at the default depth), a 16-step serial
// multiplier and a registered quarter-wave sine table. A tick after the run has ended goes
// straight to the output without using the divider. The next request is taken while a
// finished result still waits at the output.
module multi_waveform_generator #(
    parameter int SINE_TABLE_DEPTH = mwg_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream, tdata: bit 0 restart, bits 7:1 zero
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,
    // master stream, tdata: bits 15:0 port_word
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    // configuration
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);
    import mwg_pkg::*;

    localparam int LOGN = $clog2(SINE_TABLE_DEPTH);
    localparam int NUMW = FT_W + LOGN;

    t_state r_state;
    t_state n_state;

    logic [WAVE_W-1:0] r_waveform;
    logic [FREQ_W-1:0] r_frequency;
    logic [DUR_W-1:0]  r_duration;
    logic [CNT_W-1:0]  r_cnt;

    logic [CNT_W-1:0]   r_t;
    logic [PER_W-1:0]   r_period;
    logic [PER_W-1:0]   r_c;
    logic [STAIR_W-1:0] r_acc;
    logic [STAIR_W-1:0] r_thr;
    logic [4:0]         r_k;
    logic [3:0]         r_n;
    logic [29:0]        r_prod;
    logic [WORD_W-1:0]  r_res_word;
    logic               r_res_last;

    logic               r_ovalid;
    logic [WORD_W-1:0]  r_oword;
    logic               r_olast;

    logic               w_in_accept;
    logic               w_cfg_wr;
    logic [CNT_W-1:0]   w_t_now;
    logic [CNT_W-1:0]   w_limit;
    logic               w_ended;
    logic               w_out_free;
    logic [PER_W-1:0]   w_period;
    logic [PER_W-2:0]   w_half;
    logic               w_below;
    logic [PER_W-1:0]   w_rdiff;
    logic [STAIR_W-1:0] w_acc_n;
    logic [3:0]         w_n_n;
    logic [WORD_W-1:0]  w_sval;

    logic               w_div_start;
    logic [NUMW-1:0]    w_div_num;
    logic [DENW-1:0]    w_div_den;
    logic               w_div_done;
    logic [QUOW-1:0]    w_div_quo;
    logic [DENW-1:0]    w_div_rem;
    logic               w_mul_start;
    logic               w_mul_done;
    logic [FT_W-1:0]    w_mul_prod;
    logic [MAG_W-1:0]   w_mag;
    logic               w_neg;

    mwg_serial_div #(.NUMW(NUMW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    mwg_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_frequency),
        .i_b     (r_t),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    mwg_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
        .i_clk (i_clk),
        .i_idx (w_div_quo[LOGN-1:0]),
        .o_mag (w_mag),
        .o_neg (w_neg)
    );

    // handshakes and tick bookkeeping
    always_comb begin
        w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
        w_cfg_wr    = i_psel && i_penable && i_pwrite;
        w_out_free  = !r_ovalid || i_m_axis_tready;
        w_t_now     = i_s_axis_tdata[0] ? CNT_W'(1) : r_cnt;
        if (r_waveform <= WAVE_SQUARE) w_limit = CNT_W'(r_duration) * CNT_W'(10);
        else w_limit = CNT_W'(r_duration) * CNT_W'(100);
        w_ended = w_t_now >= w_limit;
    end

    // period, half period and wave helpers
    always_comb begin
        w_period = (w_div_quo < QUOW'(MIN_PERIOD)) ? PER_W'(MIN_PERIOD)
                                                   : w_div_quo[PER_W-1:0];
        w_half   = r_period[PER_W-1:1];
        w_below  = r_c < {1'b0, w_half};
        w_rdiff  = w_below ? r_c : r_c - {1'b0, w_half};
        w_acc_n  = r_acc + STAIR_W'(r_period);
        w_n_n    = r_n;
        if (w_acc_n <= r_thr) begin
            if (r_k <= 5'(STAIR_HALF)) w_n_n = r_n + 1'b1;
            else w_n_n = r_n - 1'b1;
        end
        w_sval = w_neg ? WORD_W'(16384) - WORD_W'(w_mag) : WORD_W'(16384) + WORD_W'(w_mag);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_accept) n_state = w_ended ? ST_WRITE : ST_PDIV;
            ST_PDIV:  if (w_div_done) n_state = ST_CDIV;
            ST_CDIV:  if (w_div_done) n_state = ST_SEL;
            ST_SEL: begin
                unique case (r_waveform)
                    WAVE_SINE, WAVE_SQUARE, WAVE_ABS: n_state = ST_MUL;
                    WAVE_TRI, WAVE_SAW:               n_state = ST_RDIV;
                    WAVE_STAIR:                       n_state = ST_STAIR;
                    default:                          n_state = ST_WRITE;
                endcase
            end
            ST_MUL:   if (w_mul_done) n_state = ST_PHDIV;
            ST_PHDIV: if (w_div_done) n_state = ST_ROM;
            ST_ROM:   n_state = ST_SCALE;
            ST_SCALE: n_state = (r_waveform == WAVE_SINE) ? ST_FIN : ST_WRITE;
            ST_FIN:   n_state = ST_WRITE;
            ST_RDIV:  if (w_div_done) n_state = ST_WRITE;
            ST_STAIR: if (r_k == 5'(STAIR_STEPS)) n_state = ST_WRITE;
            ST_WRITE: if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // unit launches and operands
    always_comb begin
        o_s_axis_tready = r_state == ST_IDLE;
        w_div_start = (r_state != n_state) &&
                      (n_state == ST_PDIV || n_state == ST_CDIV ||
                       n_state == ST_PHDIV || n_state == ST_RDIV);
        w_mul_start = (r_state != n_state) && (n_state == ST_MUL);
        w_div_num = '0;
        w_div_den = '0;
        unique case (n_state)
            ST_PDIV: begin
                w_div_num = NUMW'(PERIOD_NUM);
                w_div_den = (r_frequency == '0) ? DENW'(1) : DENW'(r_frequency);
            end
            ST_CDIV: begin
                w_div_num = NUMW'(r_t);
                w_div_den = DENW'(w_period);
            end
            ST_PHDIV: begin
                w_div_num = {w_mul_prod, LOGN'(0)};
                w_div_den = phase_den(r_waveform);
            end
            ST_RDIV: begin
                w_div_num = NUMW'({w_rdiff, FRAC_SHIFT'(0)});
                w_div_den = DENW'(w_half);
            end
            default: ;
        endcase
    end

    // configuration, tick counter, state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_waveform  <= WAVE_SINE;
            r_frequency <= FREQ_W'(1);
            r_duration  <= '0;
            r_cnt       <= CNT_W'(1);
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (i_paddr[3:2])
                    REG_WAVEFORM:  r_waveform  <= i_pwdata[WAVE_W-1:0];
                    REG_FREQUENCY: r_frequency <= i_pwdata[FREQ_W-1:0];
                    REG_DURATION:  r_duration  <= i_pwdata[DUR_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_accept) r_cnt <= w_ended ? w_t_now : w_t_now + 1'b1;
            if (r_state == ST_WRITE && w_out_free) r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_t        <= w_t_now;
                r_res_word <= '0;
                r_res_last <= w_ended;
            end
            ST_PDIV: if (w_div_done) r_period <= w_period;
            ST_CDIV: if (w_div_done) r_c <= w_div_rem[PER_W-1:0];
            ST_SEL: begin
                r_acc <= '0;
                r_k   <= 5'd1;
                r_n   <= '0;
                r_thr <= STAIR_W'({r_c, 4'b0}) + STAIR_W'({r_c, 2'b0}) + STAIR_W'(19);
            end
            ST_SCALE: begin
                r_prod <= 30'(w_sval) * 30'd10000;
                if (r_waveform == WAVE_SQUARE) begin
                    if (w_mag == '0) r_res_word <= 16'h4000;
                    else r_res_word <= w_neg ? 16'h0000 : 16'h8000;
                end else begin
                    r_res_word <= WORD_W'(w_mag);
                end
            end
            ST_FIN: r_res_word <= {r_prod[21:14], 8'h00};
            ST_RDIV: begin
                if (w_below) r_res_word <= WORD_W'(16384) + w_div_quo;
                else if (r_waveform == WAVE_TRI)
                    r_res_word <= WORD_W'(32768) - (w_div_quo + WORD_W'(w_div_rem != '0));
                else r_res_word <= w_div_quo;
            end
            ST_STAIR: begin
                r_acc <= w_acc_n;
                r_k   <= r_k + 1'b1;
                r_n   <= w_n_n;
                if (r_k == 5'(STAIR_STEPS)) r_res_word <= stair_level(w_n_n);
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    r_oword <= r_res_word;
                    r_olast <= r_res_last;
                end
            end
            default: ;
        endcase
    end

    // register read back
    always_comb begin
        unique case (i_paddr[3:2])
            REG_WAVEFORM:  o_prdata = 32'(r_waveform);
            REG_FREQUENCY: o_prdata = 32'(r_frequency);
            REG_DURATION:  o_prdata = 32'(r_duration);
            default:       o_prdata = '0;
        endcase
    end

    assign o_pready        = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_oword;
    assign o_m_axis_tlast  = r_olast;

    // checks
    `MWG_ASSERT_NXT(a_busy_after_request, i_clk, i_rst_n, w_in_accept, r_state != ST_IDLE)
    `MWG_ASSERT_IMP(a_last_clears_word, i_clk, i_rst_n, r_ovalid && r_olast, r_oword == '0)
    `MWG_ASSERT_IMP(a_tick_nonzero, i_clk, i_rst_n, 1'b1, r_cnt != '0)

endmodule
`default_nettype wire

// ===== src/mwg_serial_div.sv =====
`default_nettype none
module mwg_serial_div #(
    parameter int NUMW = 49
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [NUMW-1:0]           i_num,
    input  wire logic [mwg_pkg::DENW-1:0]  i_den,
    output logic                           o_done,
    output logic [mwg_pkg::QUOW-1:0]       o_quo,
    output logic [mwg_pkg::DENW-1:0]       o_rem
);
    import mwg_pkg::*;

    localparam int CW = $clog2(NUMW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [DENW-1:0] r_rem;
    logic [QUOW-1:0] r_quo;

    logic [DENW:0] w_trial;
    logic [DENW:0] w_diff;
    logic          w_ge;

    // one restoring step per cycle, numerator bits msb first
    assign w_trial = {r_rem, r_num[NUMW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUMW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUMW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DENW-1:0] : w_trial[DENW-1:0];
            r_quo <= {r_quo[QUOW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== src/mwg_serial_mul.sv =====
`default_nettype none
module mwg_serial_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mwg_pkg::FREQ_W-1:0]  i_a,
    input  wire logic [mwg_pkg::CNT_W-1:0]   i_b,
    output logic                             o_done,
    output logic [mwg_pkg::FT_W-1:0]         o_prod
);
    import mwg_pkg::*;

    localparam int CW = $clog2(FREQ_W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [FREQ_W-1:0] r_a;
    logic [FT_W-1:0]   r_b;
    logic [FT_W-1:0]   r_acc;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FREQ_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= FT_W'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_a <= {1'b0, r_a[FREQ_W-1:1]};
            r_b <= {r_b[FT_W-2:0], 1'b0};
            if (r_a[0]) r_acc <= r_acc + r_b;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// ===== src/mwg_sine_rom.sv =====
`default_nettype none
module mwg_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic [$clog2(DEPTH)-1:0]    i_idx,
    output logic [mwg_pkg::MAG_W-1:0]        o_mag,
    output logic                             o_neg
);
    import mwg_pkg::*;

    localparam int LOGN = $clog2(DEPTH);
    localparam int QN   = DEPTH / 4;

    typedef logic [MAG_W-1:0] t_qtab [0:QN];

    function automatic t_qtab build_qtab();
        t_qtab q;
        for (int j = 0; j <= QN; j++) begin
            q[j] = quarter_sine(longint'(4 * j), LOGN);
        end
        return q;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    localparam logic [LOGN:0] FULL = (LOGN + 1)'(DEPTH);
    localparam logic [LOGN:0] HALF = (LOGN + 1)'(DEPTH / 2);
    localparam logic [LOGN:0] QTR  = (LOGN + 1)'(QN);

    logic [LOGN:0] w_idx;
    logic [LOGN:0] w_j1;
    logic [LOGN:0] w_j2;
    logic          w_neg;
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;

    // fold the full turn onto the first quarter
    always_comb begin
        w_idx = {1'b0, i_idx};
        w_neg = w_idx > HALF;
        w_j1  = w_neg ? FULL - w_idx : w_idx;
        w_j2  = (w_j1 > QTR) ? HALF - w_j1 : w_j1;
    end

    // registered lookup
    always_ff @(posedge i_clk) begin
        r_mag <= QTAB[w_j2[LOGN-2:0]];
        r_neg <= w_neg;
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule
`default_nettype wire
